FILE: sv/three_phase_sine_pwm_schedule_top_macros.svh
// Assertion macros for the three-phase sine PWM schedule checker.
`ifndef THREE_PHASE_SINE_PWM_SCHEDULE_TOP_MACROS_SVH
`define THREE_PHASE_SINE_PWM_SCHEDULE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/tpsp_pkg.sv
// Package: types, constants and sine table of the three-phase sine PWM schedule.
`default_nettype none
package tpsp_pkg;

    localparam int PROGRAM_ENTRIES = 8;
    localparam int SINE_ENTRIES    = 256;
    localparam int EVENT_COUNT     = 7;
    localparam int QUEUE_DEPTH     = 2;
    localparam int TIME_W          = 11;
    localparam int IDX_W           = $clog2(PROGRAM_ENTRIES);

    localparam logic [7:0] PHASE_OFS_1 = 8'd85;
    localparam logic [7:0] PHASE_OFS_2 = 8'd170;

    localparam logic [1:0] REG_POWER_FLOOR = 2'd0;
    localparam logic [1:0] REG_DEADBAND    = 2'd1;
    localparam logic [1:0] REG_IDLE_GAP    = 2'd2;
    localparam logic [1:0] REG_PERIOD      = 2'd3;

    localparam logic [9:0] RST_POWER_FLOOR = 10'd0;
    localparam logic [7:0] RST_DEADBAND    = 8'd4;
    localparam logic [7:0] RST_IDLE_GAP    = 8'd4;
    localparam logic [9:0] RST_PERIOD      = 10'd255;

    typedef struct packed {
        logic [7:0] phase;
        logic [9:0] power;
    } t_in;

    typedef struct packed {
        logic [2:0] entry_index;
        logic [7:0] delay_ticks;
        logic [2:0] high_gates;
        logic [2:0] low_gates;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [9:0] power_floor;
        logic [7:0] deadband;
        logic [7:0] idle_gap;
        logic [9:0] period;
    } t_cfg;

    // One sorted switching program; the eighth time slot holds the period.
    typedef struct packed {
        logic [PROGRAM_ENTRIES-1:0][TIME_W-1:0] times;
        logic [PROGRAM_ENTRIES-1:0][2:0]        high;
        logic [PROGRAM_ENTRIES-1:0][2:0]        low;
    } t_prog;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_RUN,
        FS_PUSH
    } t_front_st;

    localparam logic [7:0] SINE_TABLE [SINE_ENTRIES] = '{
        8'h80, 8'h83, 8'h86, 8'h89, 8'h8c, 8'h8f, 8'h92, 8'h95,
        8'h98, 8'h9c, 8'h9f, 8'ha2, 8'ha5, 8'ha8, 8'hab, 8'hae,
        8'hb0, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbf, 8'hc1, 8'hc4,
        8'hc7, 8'hc9, 8'hcc, 8'hce, 8'hd1, 8'hd3, 8'hd5, 8'hd8,
        8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
        8'hea, 8'hec, 8'hed, 8'hef, 8'hf0, 8'hf2, 8'hf3, 8'hf5,
        8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfc,
        8'hfd, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfe,
        8'hfd, 8'hfc, 8'hfc, 8'hfb, 8'hfa, 8'hf9, 8'hf8, 8'hf7,
        8'hf6, 8'hf5, 8'hf3, 8'hf2, 8'hf0, 8'hef, 8'hed, 8'hec,
        8'hea, 8'he8, 8'he6, 8'he4, 8'he2, 8'he0, 8'hde, 8'hdc,
        8'hda, 8'hd8, 8'hd5, 8'hd3, 8'hd1, 8'hce, 8'hcc, 8'hc9,
        8'hc7, 8'hc4, 8'hc1, 8'hbf, 8'hbc, 8'hb9, 8'hb6, 8'hb3,
        8'hb0, 8'hae, 8'hab, 8'ha8, 8'ha5, 8'ha2, 8'h9f, 8'h9c,
        8'h98, 8'h95, 8'h92, 8'h8f, 8'h8c, 8'h89, 8'h86, 8'h83,
        8'h80, 8'h7c, 8'h79, 8'h76, 8'h73, 8'h70, 8'h6d, 8'h6a,
        8'h67, 8'h63, 8'h60, 8'h5d, 8'h5a, 8'h57, 8'h54, 8'h51,
        8'h4f, 8'h4c, 8'h49, 8'h46, 8'h43, 8'h40, 8'h3e, 8'h3b,
        8'h38, 8'h36, 8'h33, 8'h31, 8'h2e, 8'h2c, 8'h2a, 8'h27,
        8'h25, 8'h23, 8'h21, 8'h1f, 8'h1d, 8'h1b, 8'h19, 8'h17,
        8'h15, 8'h13, 8'h12, 8'h10, 8'h0f, 8'h0d, 8'h0c, 8'h0a,
        8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h03,
        8'h02, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h02, 8'h03, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
        8'h09, 8'h0a, 8'h0c, 8'h0d, 8'h0f, 8'h10, 8'h12, 8'h13,
        8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h21, 8'h23,
        8'h25, 8'h27, 8'h2a, 8'h2c, 8'h2e, 8'h31, 8'h33, 8'h36,
        8'h38, 8'h3b, 8'h3e, 8'h40, 8'h43, 8'h46, 8'h49, 8'h4c,
        8'h4f, 8'h51, 8'h54, 8'h57, 8'h5a, 8'h5d, 8'h60, 8'h63,
        8'h67, 8'h6a, 8'h6d, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7c
    };

endpackage
`default_nettype wire

FILE: sv/tpsp_front.sv
// Front end: takes an item, computes the three duties and builds the sorted program.
`default_nettype none
module tpsp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tpsp_pkg::t_in   i_data,
    input  wire tpsp_pkg::t_cfg  i_cfg,
    input  wire tpsp_pkg::t_q_stat i_qstat,
    output logic                 o_push,
    output tpsp_pkg::t_prog      o_prog
);

    localparam int EC = tpsp_pkg::EVENT_COUNT;
    localparam int TW = tpsp_pkg::TIME_W;

    tpsp_pkg::t_front_st r_state, n_state;
    logic [2:0]  r_step, n_step;

    logic [7:0]  r_phase;
    logic [9:0]  r_power;
    logic [17:0] r_prod;
    logic [17:0] r_est_src;
    logic [9:0]  r_est;
    logic [9:0]  r_duty [3];

    logic [7:0]    ofs;
    logic [7:0]    sine_idx;
    logic [25:0]   est_sum;
    logic [17:0]   est_x255;
    logic [17:0]   rem;
    logic [1:0]    duty_sel;
    logic          accept;

    logic [TW-1:0] t    [EC];
    logic [2:0]    rank [EC];

    assign accept = i_valid && o_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpsp_pkg::FS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            tpsp_pkg::FS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = tpsp_pkg::FS_RUN;
                    n_step  = '0;
                end
            end
            tpsp_pkg::FS_RUN: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) begin
                    n_state = tpsp_pkg::FS_PUSH;
                end
            end
            tpsp_pkg::FS_PUSH: begin
                if (!i_qstat.full) begin
                    o_push  = 1'b1;
                    n_state = tpsp_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = tpsp_pkg::FS_IDLE;
            end
        endcase
    end

    // Duty pipeline: sine * power, reciprocal estimate of /255, one-step correction
    always_comb begin
        case (r_step[1:0])
            2'd1:    ofs = tpsp_pkg::PHASE_OFS_1;
            2'd2:    ofs = tpsp_pkg::PHASE_OFS_2;
            default: ofs = 8'd0;
        endcase
        sine_idx = r_phase + ofs;
        est_sum  = 26'(r_prod) + {r_prod, 8'b0};
        est_x255 = {r_est, 8'b0} - 18'(r_est);
        rem      = r_est_src - est_x255;
        duty_sel = 2'(r_step - 3'd2);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_phase <= i_data.phase;
            r_power <= (i_data.power < i_cfg.power_floor) ? i_cfg.power_floor : i_data.power;
        end
        if (r_state == tpsp_pkg::FS_RUN) begin
            if (r_step <= 3'd2) begin
                r_prod <= 18'(tpsp_pkg::SINE_TABLE[sine_idx]) * 18'(r_power);
            end
            if (r_step >= 3'd1 && r_step <= 3'd3) begin
                r_est     <= est_sum[25:16];
                r_est_src <= r_prod;
            end
            if (r_step >= 3'd2) begin
                r_duty[duty_sel] <= r_est + 10'(rem >= 18'd255);
            end
        end
    end

    // Event times in insertion order and their stable ranks
    always_comb begin
        t[0] = '0;
        for (int k = 0; k < 3; k++) begin
            t[2*k+1] = TW'(r_duty[k]);
            t[2*k+2] = TW'(r_duty[k]) + TW'(i_cfg.deadband);
        end
        for (int i = 0; i < EC; i++) begin
            rank[i] = '0;
            for (int j = 0; j < EC; j++) begin
                if (j != i && (t[j] < t[i] || (j < i && t[j] == t[i]))) begin
                    rank[i] = rank[i] + 3'd1;
                end
            end
        end
    end

    always_comb begin
        o_prog = '0;
        for (int p = 0; p < EC; p++) begin
            for (int i = 0; i < EC; i++) begin
                if (rank[i] == 3'(p)) begin
                    o_prog.times[p] = o_prog.times[p] | t[i];
                end
            end
            for (int k = 0; k < 3; k++) begin
                o_prog.high[p][k] = !(rank[2*k+1] <= 3'(p));
                o_prog.low[p][k]  = (rank[2*k+2] <= 3'(p));
            end
        end
        o_prog.times[tpsp_pkg::PROGRAM_ENTRIES-1] = TW'(i_cfg.period);
    end

endmodule
`default_nettype wire

FILE: sv/tpsp_queue.sv
// Program queue between front and back end.
`default_nettype none
module tpsp_queue #(
    parameter int DEPTH = tpsp_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tpsp_pkg::t_prog   i_wdata,
    input  wire logic              i_pop,
    output tpsp_pkg::t_prog        o_rdata,
    output tpsp_pkg::t_q_stat      o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tpsp_pkg::t_prog r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

FILE: sv/tpsp_back.sv
// Back end: plays one queued program out as eight entries through an output register.
`default_nettype none
module tpsp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tpsp_pkg::t_prog   i_prog,
    input  wire tpsp_pkg::t_q_stat i_qstat,
    input  wire tpsp_pkg::t_cfg    i_cfg,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output tpsp_pkg::t_out         o_data
);

    localparam int IW = tpsp_pkg::IDX_W;
    localparam int TW = tpsp_pkg::TIME_W;

    logic [IW-1:0]  r_idx;
    logic           r_valid;
    tpsp_pkg::t_out r_data;

    logic [IW-1:0]  nidx;
    logic [TW-1:0]  diff;
    logic           load;
    tpsp_pkg::t_out entry;

    assign load  = !i_qstat.empty && (!r_valid || i_ready);
    assign o_pop = load && (r_idx == IW'(tpsp_pkg::PROGRAM_ENTRIES - 1));
    assign nidx  = r_idx + IW'(1);
    assign diff  = i_prog.times[nidx] - i_prog.times[r_idx];

    always_comb begin
        entry.entry_index = r_idx;
        entry.high_gates  = i_prog.high[r_idx];
        entry.low_gates   = i_prog.low[r_idx];
        entry.last        = 1'b0;
        entry.delay_ticks = diff[7:0];
        if (r_idx == IW'(tpsp_pkg::PROGRAM_ENTRIES - 1)) begin
            entry.high_gates  = '0;
            entry.low_gates   = '0;
            entry.last        = 1'b1;
            entry.delay_ticks = i_cfg.idle_gap;
        end else if (r_idx == IW'(tpsp_pkg::EVENT_COUNT - 1) &&
                     i_prog.times[r_idx] > i_prog.times[nidx]) begin
            entry.delay_ticks = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= nidx;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= entry;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

FILE: sv/three_phase_sine_pwm_schedule_top.sv
// Top level of the three-phase sine PWM schedule: configuration registers and the block.
// Each accepted (phase, power) item yields eight switching program entries, one per cycle
// at the output register while the consumer takes them. The front end takes an item through
// accept, a sine multiply and divide-by-255 pipeline shared by the three phases, and a
// sort and push step, and takes no new item until that program is pushed; the back end
// plays out eight entries per program, so its output register sets the sustained rate. A queue of
// QUEUE_DEPTH programs lets the front end work ahead while the output is stalled.
`default_nettype none
module three_phase_sine_pwm_schedule_top #(
    parameter int QUEUE_DEPTH = tpsp_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire tpsp_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output tpsp_pkg::t_out      o_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    tpsp_pkg::t_cfg    r_cfg;
    tpsp_pkg::t_prog   push_prog, head_prog;
    tpsp_pkg::t_q_stat qstat;
    logic              push, pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_floor <= tpsp_pkg::RST_POWER_FLOOR;
            r_cfg.deadband    <= tpsp_pkg::RST_DEADBAND;
            r_cfg.idle_gap    <= tpsp_pkg::RST_IDLE_GAP;
            r_cfg.period      <= tpsp_pkg::RST_PERIOD;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                tpsp_pkg::REG_POWER_FLOOR: r_cfg.power_floor <= pwdata[9:0];
                tpsp_pkg::REG_DEADBAND:    r_cfg.deadband    <= pwdata[7:0];
                tpsp_pkg::REG_IDLE_GAP:    r_cfg.idle_gap    <= pwdata[7:0];
                tpsp_pkg::REG_PERIOD:      r_cfg.period      <= pwdata[9:0];
                default:                   r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tpsp_pkg::REG_POWER_FLOOR: prdata = 32'(r_cfg.power_floor);
            tpsp_pkg::REG_DEADBAND:    prdata = 32'(r_cfg.deadband);
            tpsp_pkg::REG_IDLE_GAP:    prdata = 32'(r_cfg.idle_gap);
            tpsp_pkg::REG_PERIOD:      prdata = 32'(r_cfg.period);
            default:                   prdata = '0;
        endcase
    end

    tpsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_prog  (push_prog)
    );

    tpsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_prog),
        .i_pop   (pop),
        .o_rdata (head_prog),
        .o_stat  (qstat)
    );

    tpsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prog  (head_prog),
        .i_qstat (qstat),
        .i_cfg   (r_cfg),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

FILE: sv/tpsp_checker.sv
// Port-level checker for the three-phase sine PWM schedule, bound to the top level.
`default_nettype none
`include "three_phase_sine_pwm_schedule_top_macros.svh"
module tpsp_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire tpsp_pkg::t_out o_data
);

    `TPSP_ASSERT_IMPLY(a_last_is_final, i_clk, i_rst_n, o_valid, (o_data.last == (o_data.entry_index == 3'd7)))
    `TPSP_ASSERT_IMPLY(a_closing_all_off, i_clk, i_rst_n, o_valid && o_data.last, (o_data.high_gates == 3'd0) && (o_data.low_gates == 3'd0))
    `TPSP_ASSERT_NEXT(a_index_steps, i_clk, i_rst_n, o_valid && i_ready && !o_data.last, !o_valid || (o_data.entry_index == $past(o_data.entry_index) + 3'd1))
    `TPSP_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))

endmodule

bind three_phase_sine_pwm_schedule_top tpsp_checker u_tpsp_checker (.*);
`default_nettype wire

FILE: tb/three_phase_sine_pwm_schedule_top_tb.sv
// Testbench for the three-phase sine PWM schedule: predicts and checks every program entry.
`timescale 1ns / 100ps

module three_phase_sine_pwm_schedule_top_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ROUNDS = 9;
    localparam int ROUND_ITEMS   = 50;
    localparam int EVENTS        = tpsp_pkg::EVENT_COUNT;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    tpsp_pkg::t_in  i_data;
    logic           o_valid;
    logic           i_ready;
    tpsp_pkg::t_out o_data;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [3:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    tpsp_pkg::t_cfg cfg;
    tpsp_pkg::t_out pending_entries[$];
    int             entry_errors;
    int             cycle_count;
    bit             steady_flow;

    three_phase_sine_pwm_schedule_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        entry_errors = 0;
        cycle_count = 0;
        steady_flow = 1'b0;
        cfg.power_floor = tpsp_pkg::RST_POWER_FLOOR;
        cfg.deadband = tpsp_pkg::RST_DEADBAND;
        cfg.idle_gap = tpsp_pkg::RST_IDLE_GAP;
        cfg.period = tpsp_pkg::RST_PERIOD;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("three_phase_sine_pwm_schedule_top: mismatch");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        entry_errors++;
        if (entry_errors <= 10) begin
            $display("%s", what);
        end
    endtask

    // Stable time sort of the seven switching events, then eight program entries.
    task automatic predict_program(input tpsp_pkg::t_in item);
        int             raw_when[EVENTS];
        logic [2:0]     raw_clr[EVENTS];
        logic [2:0]     raw_set[EVENTS];
        int             evt_when[EVENTS];
        logic [2:0]     evt_clr[EVENTS];
        logic [2:0]     evt_set[EVENTS];
        int             n;
        int             pos;
        int             pw;
        int             duty;
        logic [7:0]     idx;
        logic [7:0]     ofs;
        logic [2:0]     hi;
        logic [2:0]     lo;
        tpsp_pkg::t_out entry;
        pw = int'(item.power);
        if (pw < int'(cfg.power_floor)) begin
            pw = int'(cfg.power_floor);
        end
        raw_when[0] = 0;
        raw_clr[0] = 3'b000;
        raw_set[0] = 3'b000;
        for (int k = 0; k < 3; k++) begin
            ofs = (k == 0) ? 8'd0 : (k == 1) ? tpsp_pkg::PHASE_OFS_1 : tpsp_pkg::PHASE_OFS_2;
            idx = item.phase + ofs;
            duty = (int'(tpsp_pkg::SINE_TABLE[idx]) * pw) / 255;
            raw_when[1 + 2 * k] = duty;
            raw_clr[1 + 2 * k] = 3'b001 << k;
            raw_set[1 + 2 * k] = 3'b000;
            raw_when[2 + 2 * k] = duty + int'(cfg.deadband);
            raw_clr[2 + 2 * k] = 3'b000;
            raw_set[2 + 2 * k] = 3'b001 << k;
        end
        n = 0;
        for (int e = 0; e < EVENTS; e++) begin
            pos = 0;
            while (pos < n && evt_when[pos] <= raw_when[e]) begin
                pos++;
            end
            for (int j = n; j > pos; j--) begin
                evt_when[j] = evt_when[j - 1];
                evt_clr[j] = evt_clr[j - 1];
                evt_set[j] = evt_set[j - 1];
            end
            evt_when[pos] = raw_when[e];
            evt_clr[pos] = raw_clr[e];
            evt_set[pos] = raw_set[e];
            n++;
        end
        hi = 3'b111;
        lo = 3'b000;
        for (int k = 0; k < EVENTS; k++) begin
            hi = hi & ~evt_clr[k];
            lo = lo | evt_set[k];
            entry.entry_index = k[2:0];
            if (k + 1 < EVENTS) begin
                entry.delay_ticks = 8'(evt_when[k + 1] - evt_when[k]);
            end else if (evt_when[k] > int'(cfg.period)) begin
                entry.delay_ticks = 8'd0;
            end else begin
                entry.delay_ticks = 8'(int'(cfg.period) - evt_when[k]);
            end
            entry.high_gates = hi;
            entry.low_gates = lo;
            entry.last = 1'b0;
            pending_entries.push_back(entry);
        end
        entry.entry_index = 3'(tpsp_pkg::PROGRAM_ENTRIES - 1);
        entry.delay_ticks = cfg.idle_gap;
        entry.high_gates = 3'b000;
        entry.low_gates = 3'b000;
        entry.last = 1'b1;
        pending_entries.push_back(entry);
    endtask

    always @(posedge i_clk) begin
        tpsp_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_entries.size() == 0) begin
                flag_mismatch($sformatf("unexpected entry: idx %0d dly %0d hi %b lo %b last %b",
                    o_data.entry_index, o_data.delay_ticks, o_data.high_gates,
                    o_data.low_gates, o_data.last));
            end else begin
                want = pending_entries.pop_front();
                if (o_data.entry_index !== want.entry_index
                        || o_data.delay_ticks !== want.delay_ticks
                        || o_data.high_gates !== want.high_gates
                        || o_data.low_gates !== want.low_gates
                        || o_data.last !== want.last) begin
                    flag_mismatch($sformatf({
                        "entry mismatch: exp idx %0d dly %0d hi %b lo %b last %b,",
                        " got idx %0d dly %0d hi %b lo %b last %b"},
                        want.entry_index, want.delay_ticks, want.high_gates,
                        want.low_gates, want.last, o_data.entry_index, o_data.delay_ticks,
                        o_data.high_gates, o_data.low_gates, o_data.last));
                end
            end
        end
    end

    // Output side: random stall before each transfer, unless steady flow is set.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_command(input logic [7:0] ph, input logic [9:0] pw);
        int            gap;
        tpsp_pkg::t_in item;
        item.phase = ph;
        item.power = pw;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data <= item;
        do @(posedge i_clk); while (!o_ready);
        predict_program(item);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] register_value(input logic [1:0] reg_idx);
        case (reg_idx)
            tpsp_pkg::REG_POWER_FLOOR: return 32'(cfg.power_floor);
            tpsp_pkg::REG_DEADBAND:    return 32'(cfg.deadband);
            tpsp_pkg::REG_IDLE_GAP:    return 32'(cfg.idle_gap);
            default:                   return 32'(cfg.period);
        endcase
    endfunction

    task automatic read_register(input logic [1:0] reg_idx);
        logic [31:0] got;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {reg_idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== register_value(reg_idx)) begin
            flag_mismatch($sformatf("register %0d readback: exp %0d got %0d",
                reg_idx, register_value(reg_idx), got));
        end
    endtask

    task automatic write_register(input logic [1:0] reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_idx)
            tpsp_pkg::REG_POWER_FLOOR: cfg.power_floor = value[9:0];
            tpsp_pkg::REG_DEADBAND:    cfg.deadband = value[7:0];
            tpsp_pkg::REG_IDLE_GAP:    cfg.idle_gap = value[7:0];
            default:                   cfg.period = value[9:0];
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        read_register(reg_idx);
    endtask

    task automatic apply_settings(input logic [9:0] mp, input logic [7:0] db,
                                  input logic [7:0] ig, input logic [9:0] pd);
        wait_drained();
        write_register(tpsp_pkg::REG_POWER_FLOOR, 32'(mp));
        write_register(tpsp_pkg::REG_DEADBAND, 32'(db));
        write_register(tpsp_pkg::REG_IDLE_GAP, 32'(ig));
        write_register(tpsp_pkg::REG_PERIOD, 32'(pd));
    endtask

    task automatic test_register_reset();
        read_register(tpsp_pkg::REG_POWER_FLOOR);
        read_register(tpsp_pkg::REG_DEADBAND);
        read_register(tpsp_pkg::REG_IDLE_GAP);
        read_register(tpsp_pkg::REG_PERIOD);
    endtask

    task automatic test_default_program();
        send_command(8'd0, 10'd0);
        send_command(8'd0, 10'd1023);
        send_command(8'd255, 10'd1023);
        send_command(8'd64, 10'd700);
        send_command(8'd128, 10'd1);
        send_command(8'd192, 10'd512);
    endtask

    // Small powers are raised to the power floor; long deadband and idle gap.
    task automatic test_forced_power_floor();
        apply_settings(10'd1023, 8'd255, 8'd255, 10'd1023);
        send_command(8'd0, 10'd0);
        send_command(8'd170, 10'd1023);
    endtask

    // Equal event times keep insertion order; seventh entry past the period.
    task automatic test_coincident_events();
        apply_settings(10'd0, 8'd0, 8'd0, 10'd0);
        send_command(8'd0, 10'd0);
        send_command(8'd85, 10'd1023);
    endtask

    // Gaps of 256 ticks or more wrap in the 8-bit delay.
    task automatic test_wrapped_delays();
        apply_settings(10'd300, 8'd255, 8'd128, 10'd1023);
        send_command(8'd64, 10'd1023);
        send_command(8'd200, 10'd0);
    endtask

    function automatic logic [9:0] pick_setting(input int max_value);
        case ($urandom_range(0, 3))
            0:       return 10'(0);
            1:       return 10'(max_value);
            default: return 10'($urandom_range(0, max_value));
        endcase
    endfunction

    task automatic test_random_programs();
        logic [9:0] pw;
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            if (r > 0) begin
                apply_settings(pick_setting(1023), 8'(pick_setting(255)),
                               8'(pick_setting(255)), pick_setting(1023));
            end
            for (int i = 0; i < ROUND_ITEMS; i++) begin
                if (i % 16 == 0) begin
                    steady_flow = ($urandom_range(0, 3) == 0);
                end
                if (cfg.power_floor != 0 && $urandom_range(0, 3) == 0) begin
                    pw = 10'($urandom_range(0, cfg.power_floor));
                end else begin
                    pw = 10'($urandom_range(0, 1023));
                end
                send_command(8'($urandom_range(0, 255)), pw);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_reset();
        test_default_program();
        test_forced_power_floor();
        test_coincident_events();
        test_wrapped_delays();
        test_random_programs();
        wait_drained();
        if (entry_errors == 0 && pending_entries.size() == 0) begin
            $display("three_phase_sine_pwm_schedule_top: match");
        end else begin
            $display("three_phase_sine_pwm_schedule_top: mismatch");
        end
        $finish;
    end

endmodule

FILE: three_phase_sine_pwm_schedule_top.f
+incdir+sv
sv/tpsp_pkg.sv
sv/tpsp_front.sv
sv/tpsp_queue.sv
sv/tpsp_back.sv
sv/three_phase_sine_pwm_schedule_top.sv
sv/tpsp_checker.sv
tb/three_phase_sine_pwm_schedule_top_tb.sv
